>>> rtl/tsp_pkg.sv
// ============================================================================
// Typed subtract package
// Type codes, stage records and operand decode helpers shared by the core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

	localparam logic [3:0] TY_BOOL = 4'd0;
	localparam logic [3:0] TY_I8   = 4'd1;
	localparam logic [3:0] TY_U8   = 4'd2;
	localparam logic [3:0] TY_I16  = 4'd3;
	localparam logic [3:0] TY_U16  = 4'd4;
	localparam logic [3:0] TY_I32  = 4'd5;
	localparam logic [3:0] TY_U32  = 4'd6;
	localparam logic [3:0] TY_I64  = 4'd7;
	localparam logic [3:0] TY_U64  = 4'd8;
	localparam logic [3:0] TY_F32  = 4'd9;
	localparam logic [3:0] TY_F64  = 4'd10;
	localparam logic [3:0] TY_PTR  = 4'd11;

	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	// Finite magnitude: leading bit of m weighs 2**x once normalized.
	typedef struct packed {
		logic               s;
		logic [63:0]        m;
		logic signed [12:0] x;
	} fnum_t;

	typedef struct packed {
		logic        nan;
		logic        inf;
		logic        zero;
		logic [63:0] nanb;
		fnum_t       n;
	} opnd_t;

	typedef struct packed {
		logic        fp;
		logic        dbl;
		logic [3:0]  rtype;
		logic [63:0] rval;
		logic        ok;
	} meta_t;

	function automatic logic is_sgn(input logic [3:0] t);
		return (t == TY_I8) || (t == TY_I16) || (t == TY_I32) || (t == TY_I64);
	endfunction

	function automatic logic [1:0] int_wc(input logic [3:0] t);
		logic [1:0] w;
		case (t) inside
			TY_I8, TY_U8:   w = WC_8;
			TY_I16, TY_U16: w = WC_16;
			TY_I32, TY_U32: w = WC_32;
			default:        w = WC_64;
		endcase
		return w;
	endfunction

	function automatic logic [63:0] mask_w(input logic [3:0] t);
		logic [63:0] r;
		case (t) inside
			TY_I8, TY_U8:   r = 64'h0000_0000_0000_00FF;
			TY_I16, TY_U16: r = 64'h0000_0000_0000_FFFF;
			TY_I32, TY_U32: r = 64'h0000_0000_FFFF_FFFF;
			default:        r = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] extend(input logic [3:0] t, input logic [63:0] v);
		logic [63:0] r;
		case (t)
			TY_I8:   r = {{56{v[7]}}, v[7:0]};
			TY_U8:   r = {56'd0, v[7:0]};
			TY_I16:  r = {{48{v[15]}}, v[15:0]};
			TY_U16:  r = {48'd0, v[15:0]};
			TY_I32:  r = {{32{v[31]}}, v[31:0]};
			TY_U32:  r = {32'd0, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] lzc65(input logic [64:0] v);
		logic [6:0] n;
		n = 7'd65;
		for (int i = 0; i < 65; i++) begin
			if (v[i]) begin
				n = 7'(64 - i);
			end
		end
		return n;
	endfunction

	function automatic opnd_t unpack(input logic [3:0] t, input logic [63:0] v,
		input logic dbl);
		opnd_t       o;
		logic [63:0] e;
		logic        neg;
		o = '0;
		e = extend(t, v);
		neg = is_sgn(t) & e[63];
		if (t == TY_F64) begin
			o.n.s = v[63];
			o.n.m = {(v[62:52] != 11'd0), v[51:0], 11'd0};
			o.n.x = (v[62:52] == 11'd0) ? -13'sd1022 :
				($signed({2'b00, v[62:52]}) - 13'sd1023);
			o.nan = (&v[62:52]) & (|v[51:0]);
			o.inf = (&v[62:52]) & ~(|v[51:0]);
			o.nanb = {v[63], 11'h7FF, 1'b1, v[50:0]};
		end else if (t == TY_F32) begin
			o.n.s = v[31];
			o.n.m = {(v[30:23] != 8'd0), v[22:0], 40'd0};
			o.n.x = (v[30:23] == 8'd0) ? -13'sd126 :
				($signed({5'b00000, v[30:23]}) - 13'sd127);
			o.nan = (&v[30:23]) & (|v[22:0]);
			o.inf = (&v[30:23]) & ~(|v[22:0]);
			o.nanb = dbl ? {v[31], 11'h7FF, 1'b1, v[21:0], 29'd0} :
				{32'd0, v[31], 8'hFF, 1'b1, v[21:0]};
		end else begin
			o.n.s = neg;
			o.n.m = neg ? (~e + 64'd1) : e;
			o.n.x = 13'sd63;
		end
		o.zero = ~o.nan & ~o.inf & (o.n.m == 64'd0);
		return o;
	endfunction

	// Rounds a normalized operand to the target precision, nearest even.
	function automatic fnum_t round_op(input fnum_t a, input logic dbl);
		fnum_t       r;
		logic [64:0] low;
		logic [64:0] inc;
		logic [64:0] sum;
		logic        lsb;
		logic        grd;
		logic        stk;
		r = a;
		low = dbl ? 65'h0_0000_0000_0000_07FF : 65'h0_0000_00FF_FFFF_FFFF;
		inc = dbl ? 65'h0_0000_0000_0000_0800 : 65'h0_0000_0100_0000_0000;
		lsb = dbl ? a.m[11] : a.m[40];
		grd = dbl ? a.m[10] : a.m[39];
		stk = dbl ? (|a.m[9:0]) : (|a.m[38:0]);
		sum = ({1'b0, a.m} & ~low) + ((grd & (lsb | stk)) ? inc : 65'd0);
		if (sum[64]) begin
			r.m = {1'b1, 63'd0};
			r.x = a.x + 13'sd1;
		end else begin
			r.m = sum[63:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/typed_subtract_with_promotion_core.sv
// ============================================================================
// Typed subtract with promotion
// Subtracts two tagged operands with integer and floating point promotion.
// ============================================================================
// The input channel takes one beat per cycle: two operands, each a type code
// and 64 raw bits. The output channel returns one beat per input beat, in
// order: the result type, the difference bits at the result width with the
// upper bits zero, and ok. A bool, pointer or undefined type code on either
// side gives ok low with the left operand passed through unchanged.
// Integer differences wrap at the result width. When a float takes part, an
// integer operand is rounded to that precision and the difference is
// rounded to nearest even, with IEEE handling of subnormals, NaN and inf.
// Every beat passes through the eleven stage float path (operand normalize
// and round, align, add, normalize, round, pack). Throughput is one beat per
// cycle while the output is not stalled.
// Reset clears all stage valid bits, so the output is empty afterward.
// When the receiver stalls with a beat held at the output, the whole
// pipeline holds and in_ready drops in the same cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module typed_subtract_with_promotion_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  left_type,
	input  wire logic [63:0] left_value,
	input  wire logic [3:0]  right_type,
	input  wire logic [63:0] right_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       result_type,
	output logic [63:0]      result_value,
	output logic             ok
);
	import tsp_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	meta_t meta_s7, meta_s8, meta_s9, meta_s10;

	fnum_t a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, a_s4, b_s4;
	logic [6:0] za_s2, zb_s2;

	logic [63:0]        mb_s5, ms_s5, mb_s6, al_s6;
	logic signed [12:0] xb_s5, xb_s6, xb_s7, xb_s8;
	logic [6:0]         d_s5;
	logic               sg_s5, sg_s6, sg_s7, sg_s8, sg_s9, sg_s10;
	logic               sub_s5, sub_s6;
	logic [64:0]        r_s7, r_s8, rn_s9;
	logic [6:0]         z_s8, k_s10;
	logic               rz_s8, rz_s9, rz_s10;
	logic signed [12:0] en_s9, ee_s10;
	logic [66:0]        rr_s10;
	logic [3:0]         rt_s11;
	logic [63:0]        rv_s11;
	logic               ok_s11;

	assign en = ~v_s11 | out_ready;
	assign in_ready = en;

	// Decode, integer difference and special results.
	meta_t meta_d1;
	fnum_t a_d1, b_d1;
	always_comb begin
		opnd_t       ua;
		opnd_t       ub;
		logic        rej;
		logic        dbl;
		logic        fpath;
		logic        spc;
		logic [63:0] spv;
		logic [63:0] infz;
		logic [3:0]  rti;
		logic [1:0]  wl;
		logic [1:0]  wr;
		rej = (left_type < TY_I8) || (left_type > TY_F64) ||
			(right_type < TY_I8) || (right_type > TY_F64);
		dbl = (left_type == TY_F64) || (right_type == TY_F64);
		fpath = dbl || (left_type == TY_F32) || (right_type == TY_F32);
		ua = unpack(left_type, left_value, dbl);
		ub = unpack(right_type, right_value, dbl);
		wl = int_wc(left_type);
		wr = int_wc(right_type);
		if (wl == WC_8) begin
			rti = (wr <= WC_16) ? TY_I32 : right_type;
		end else begin
			rti = (wr < wl) ? left_type : right_type;
		end
		infz = dbl ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
		spc = 1'b1;
		spv = 64'd0;
		if (ua.nan) begin
			spv = ua.nanb;
		end else if (ub.nan) begin
			spv = ub.nanb;
		end else if (ua.inf && ub.inf && (ua.n.s == ub.n.s)) begin
			spv = dbl ? 64'hFFF8_0000_0000_0000 : 64'h0000_0000_FFC0_0000;
		end else if (ua.inf) begin
			spv = infz | (dbl ? {ua.n.s, 63'd0} : {32'd0, ua.n.s, 31'd0});
		end else if (ub.inf) begin
			spv = infz | (dbl ? {~ub.n.s, 63'd0} : {32'd0, ~ub.n.s, 31'd0});
		end else if (ua.zero && ub.zero) begin
			spv = dbl ? {ua.n.s & ~ub.n.s, 63'd0} : {32'd0, ua.n.s & ~ub.n.s, 31'd0};
		end else begin
			spc = 1'b0;
		end
		meta_d1.ok = ~rej;
		meta_d1.dbl = dbl;
		meta_d1.fp = ~rej & fpath & ~spc;
		meta_d1.rtype = rej ? left_type : (fpath ? (dbl ? TY_F64 : TY_F32) : rti);
		meta_d1.rval = rej ? left_value : (fpath ? spv :
			((extend(left_type, left_value) - extend(right_type, right_value)) &
			mask_w(rti)));
		a_d1 = ua.n;
		b_d1 = ub.n;
		b_d1.s = ~ub.n.s;
	end

	// Operand normalize, compare, alignment and add.
	fnum_t a_d3, b_d3;
	always_comb begin
		a_d3 = a_s2;
		b_d3 = b_s2;
		a_d3.m = a_s2.m << za_s2;
		b_d3.m = b_s2.m << zb_s2;
		a_d3.x = a_s2.x - $signed({6'd0, za_s2});
		b_d3.x = b_s2.x - $signed({6'd0, zb_s2});
	end

	logic [63:0]        mb_d5, ms_d5;
	logic signed [12:0] xb_d5;
	logic [6:0]         d_d5;
	logic               sg_d5;
	always_comb begin
		logic               za;
		logic               zb;
		logic               abig;
		logic signed [12:0] dd;
		fnum_t              big;
		fnum_t              sml;
		za = ~a_s4.m[63];
		zb = ~b_s4.m[63];
		abig = zb | (~za & ((a_s4.x > b_s4.x) ||
			((a_s4.x == b_s4.x) && (a_s4.m >= b_s4.m))));
		big = abig ? a_s4 : b_s4;
		sml = abig ? b_s4 : a_s4;
		dd = big.x - sml.x;
		mb_d5 = big.m;
		ms_d5 = sml.m;
		xb_d5 = big.x;
		sg_d5 = big.s;
		if (~sml.m[63]) begin
			d_d5 = 7'd0;
		end else if (dd > 13'sd66) begin
			d_d5 = 7'd66;
		end else begin
			d_d5 = dd[6:0];
		end
	end

	logic [63:0] al_d6;
	assign al_d6 = (ms_s5 >> d_s5) | {63'd0, |(ms_s5 & ~({64{1'b1}} << d_s5))};

	logic [64:0] r_d7;
	assign r_d7 = sub_s6 ? ({1'b0, mb_s6} - {1'b0, al_s6}) :
		({1'b0, mb_s6} + {1'b0, al_s6});

	// Result normalize, round and pack.
	logic [64:0]        rn_d9;
	logic signed [12:0] en_d9;
	assign rn_d9 = r_s8 << z_s8;
	assign en_d9 = xb_s8 + 13'sd1 - $signed({6'd0, z_s8});

	logic [66:0]        rr_d10;
	logic [6:0]         k_d10;
	logic signed [12:0] ee_d10;
	always_comb begin
		logic signed [12:0] emin;
		logic signed [12:0] kk;
		logic [66:0]        r67;
		logic               lsb;
		logic               grd;
		logic               stk;
		emin = meta_s9.dbl ? -13'sd1022 : -13'sd126;
		ee_d10 = (en_s9 < emin) ? emin : en_s9;
		kk = (meta_s9.dbl ? 13'sd12 : 13'sd41) + (ee_d10 - en_s9);
		k_d10 = (kk > 13'sd66) ? 7'd66 : kk[6:0];
		r67 = {2'b00, rn_s9};
		lsb = r67[k_d10];
		grd = r67[k_d10 - 7'd1];
		stk = |(r67 & ~({67{1'b1}} << (k_d10 - 7'd1)));
		rr_d10 = (r67 & ({67{1'b1}} << k_d10)) +
			((grd & (lsb | stk)) ? (67'd1 << k_d10) : 67'd0);
	end

	logic [63:0] rv_d11;
	always_comb begin
		logic [66:0]        fld;
		logic signed [12:0] pexp;
		logic               ovf;
		logic [63:0]        fpv;
		fld = rr_s10 >> k_s10;
		pexp = ee_s10 + (meta_s10.dbl ? 13'sd1022 : 13'sd126) +
			$signed({11'd0, (meta_s10.dbl ? fld[53:52] : fld[24:23])});
		ovf = pexp >= (meta_s10.dbl ? 13'sd2047 : 13'sd255);
		if (rz_s10) begin
			fpv = 64'd0;
		end else if (ovf) begin
			fpv = meta_s10.dbl ? {sg_s10, 11'h7FF, 52'd0} : {32'd0, sg_s10, 8'hFF, 23'd0};
		end else begin
			fpv = meta_s10.dbl ? {sg_s10, pexp[10:0], fld[51:0]} :
				{32'd0, sg_s10, pexp[7:0], fld[22:0]};
		end
		rv_d11 = meta_s10.fp ? fpv : meta_s10.rval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_d1;
			a_s1 <= a_d1;
			b_s1 <= b_d1;

			meta_s2 <= meta_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			za_s2 <= lzc65({a_s1.m, 1'b1});
			zb_s2 <= lzc65({b_s1.m, 1'b1});

			meta_s3 <= meta_s2;
			a_s3 <= a_d3;
			b_s3 <= b_d3;

			meta_s4 <= meta_s3;
			a_s4 <= round_op(a_s3, meta_s3.dbl);
			b_s4 <= round_op(b_s3, meta_s3.dbl);

			meta_s5 <= meta_s4;
			mb_s5 <= mb_d5;
			ms_s5 <= ms_d5;
			xb_s5 <= xb_d5;
			d_s5 <= d_d5;
			sg_s5 <= sg_d5;
			sub_s5 <= a_s4.s ^ b_s4.s;

			meta_s6 <= meta_s5;
			mb_s6 <= mb_s5;
			al_s6 <= al_d6;
			xb_s6 <= xb_s5;
			sg_s6 <= sg_s5;
			sub_s6 <= sub_s5;

			meta_s7 <= meta_s6;
			r_s7 <= r_d7;
			xb_s7 <= xb_s6;
			sg_s7 <= sg_s6;

			meta_s8 <= meta_s7;
			r_s8 <= r_s7;
			z_s8 <= lzc65(r_s7);
			rz_s8 <= (r_s7 == 65'd0);
			xb_s8 <= xb_s7;
			sg_s8 <= sg_s7;

			meta_s9 <= meta_s8;
			rn_s9 <= rn_d9;
			en_s9 <= en_d9;
			sg_s9 <= sg_s8;
			rz_s9 <= rz_s8;

			meta_s10 <= meta_s9;
			rr_s10 <= rr_d10;
			k_s10 <= k_d10;
			ee_s10 <= ee_d10;
			sg_s10 <= sg_s9;
			rz_s10 <= rz_s9;

			rt_s11 <= meta_s10.rtype;
			rv_s11 <= rv_d11;
			ok_s11 <= meta_s10.ok;
		end
	end

	assign out_valid = v_s11;
	assign result_type = rt_s11;
	assign result_value = rv_s11;
	assign ok = ok_s11;

	a_f32_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok && (result_type == TY_F32)) |-> (result_value[63:32] == 32'd0))
		else $error("f32 result has nonzero upper bits");

	a_ok_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok) |-> ((result_type != TY_BOOL) && (result_type != TY_PTR) &&
		(result_type <= TY_F64)))
		else $error("accepted result carries a rejected type");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(v_s5) && $stable(v_s10) && $stable(v_s1)))
		else $error("pipeline moved during an output stall");

endmodule

`default_nettype wire

>>> test/typed_subtract_with_promotion_core_tb.sv
// ============================================================================
// Typed subtract with promotion testbench
// Drives tagged operand pairs through the core under random input idling and
// output stalls, predicts each difference with an independent model of the
// promotion rules and IEEE rounding, and checks every output beat in order.
// ============================================================================
`timescale 1ns / 1ps

module typed_subtract_with_promotion_core_tb;
	import tsp_pkg::*;

	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		logic [3:0]  ty;
		logic [63:0] val;
		logic        acc;
	} diff_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  left_type = '0;
	logic [63:0] left_value = '0;
	logic [3:0]  right_type = '0;
	logic [63:0] right_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  result_type;
	logic [63:0] result_value;
	logic        ok;

	diff_t pending_diffs[$];
	int    mismatches = 0;
	int    beats_sent = 0;
	int    beats_checked = 0;
	int    n_int = 0;
	int    n_float = 0;
	int    n_reject = 0;
	int    idle_cycles = 0;
	int    rx_cycle = 0;
	int    hold_until = 0;
	logic  calm = 1'b0;

	typed_subtract_with_promotion_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_type(left_type), .left_value(left_value),
		.right_type(right_type), .right_value(right_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_type(result_type), .result_value(result_value), .ok(ok)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int int_width(input logic [3:0] t);
		case (t)
			TY_I8, TY_U8:   return 8;
			TY_I16, TY_U16: return 16;
			TY_I32, TY_U32: return 32;
			default:        return 64;
		endcase
	endfunction

	function automatic logic is_signed_ty(input logic [3:0] t);
		return t == TY_I8 || t == TY_I16 || t == TY_I32 || t == TY_I64;
	endfunction

	function automatic logic [63:0] low_mask(input int w);
		return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic logic [63:0] widen_int(input logic [3:0] t, input logic [63:0] v);
		int          w;
		logic [63:0] x;
		w = int_width(t);
		x = v & low_mask(w);
		if (is_signed_ty(t) && w < 64 && x[w-1])
			x = x | ~low_mask(w);
		return x;
	endfunction

	// Rounds s * m * 2**e2 to nearest even at single or double precision.
	function automatic logic [63:0] round_float(input logic s, input logic [63:0] m,
		input int e2, input logic dbl);
		int           prec;
		int           emin;
		int           bias;
		int           msb;
		int           e;
		int           shift;
		logic [127:0] w;
		logic [63:0]  q;
		logic         g;
		logic         st;
		logic [63:0]  fr;
		prec = dbl ? 53 : 24;
		emin = dbl ? -1022 : -126;
		bias = dbl ? 1023 : 127;
		if (m == 0)
			return dbl ? {s, 63'd0} : {32'd0, s, 31'd0};
		msb = 0;
		for (int i = 0; i < 64; i++)
			if (m[i])
				msb = i;
		e = msb + e2;
		if (e < emin)
			e = emin;
		shift = (e - prec + 1) - e2;
		if (shift <= 0) begin
			q = m << (-shift);
		end else begin
			if (shift > 127) begin
				q = '0;
				g = 1'b0;
				st = 1'b1;
			end else begin
				w = {m, 64'd0} >> shift;
				q = w[127:64];
				g = w[63];
				st = |w[62:0];
			end
			if (g && (st || q[0]))
				q = q + 64'd1;
			if (q[prec]) begin
				q = q >> 1;
				e = e + 1;
			end
		end
		if (e > bias)
			return dbl ? {s, 11'h7FF, 52'd0} : {32'd0, s, 8'hFF, 23'd0};
		fr = q & low_mask(prec - 1);
		if (!q[prec-1])
			e = 1 - bias;
		if (dbl)
			return {s, 11'(q[prec-1] ? e + bias : 0), fr[51:0]};
		return {32'd0, s, 8'(q[prec-1] ? e + bias : 0), fr[22:0]};
	endfunction

	function automatic logic [63:0] int_to_float(input logic [3:0] t, input logic [63:0] v,
		input logic dbl);
		logic [63:0] x;
		logic        neg;
		x = widen_int(t, v);
		neg = is_signed_ty(t) && x[63];
		return round_float(neg, neg ? (~x + 64'd1) : x, 0, dbl);
	endfunction

	function automatic logic [63:0] single_to_double(input logic [31:0] b);
		if (b[30:23] == 8'hFF)
			return (b[22:0] != 0) ? {b[31], 11'h7FF, 1'b1, b[21:0], 29'd0} :
				{b[31], 11'h7FF, 52'd0};
		if (b[30:23] == 8'd0)
			return round_float(b[31], {41'd0, b[22:0]}, -149, 1'b1);
		return round_float(b[31], {40'd0, 1'b1, b[22:0]}, int'(b[30:23]) - 150, 1'b1);
	endfunction

	function automatic logic [63:0] double_to_single(input logic [63:0] b);
		if (b[62:52] == 11'h7FF)
			return (b[51:0] != 0) ? {32'd0, b[63], 8'hFF, 1'b1, b[50:29]} :
				{32'd0, b[63], 8'hFF, 23'd0};
		if (b[62:52] == 11'd0)
			return round_float(b[63], {12'd0, b[51:0]}, -1074, 1'b0);
		return round_float(b[63], {11'd0, 1'b1, b[51:0]}, int'(b[62:52]) - 1075, 1'b0);
	endfunction

	function automatic logic [63:0] as_double(input logic [3:0] t, input logic [63:0] v);
		if (t == TY_F64)
			return v;
		if (t == TY_F32)
			return single_to_double(v[31:0]);
		return int_to_float(t, v, 1'b1);
	endfunction

	function automatic logic [63:0] as_single(input logic [3:0] t, input logic [63:0] v);
		if (t == TY_F32)
			return {32'd0, v[31:0]};
		return int_to_float(t, v, 1'b0);
	endfunction

	function automatic diff_t predict_difference(input logic [3:0] lt, input logic [63:0] lv,
		input logic [3:0] rt, input logic [63:0] rv);
		diff_t       d;
		int          wl;
		int          wr;
		real         a;
		real         b;
		logic [63:0] sa;
		logic [63:0] sb;
		d.acc = 1'b1;
		if (lt < TY_I8 || lt > TY_F64 || rt < TY_I8 || rt > TY_F64) begin
			d.ty = lt;
			d.val = lv;
			d.acc = 1'b0;
		end else if (lt == TY_F64 || rt == TY_F64) begin
			a = $bitstoreal(as_double(lt, lv));
			b = $bitstoreal(as_double(rt, rv));
			d.ty = TY_F64;
			d.val = $realtobits(a - b);
		end else if (lt == TY_F32 || rt == TY_F32) begin
			// Double holds the exact operands and rounds the difference
			// finely enough that narrowing afterward matches single math.
			sa = as_single(lt, lv);
			sb = as_single(rt, rv);
			a = $bitstoreal(single_to_double(sa[31:0]));
			b = $bitstoreal(single_to_double(sb[31:0]));
			d.ty = TY_F32;
			d.val = double_to_single($realtobits(a - b));
		end else begin
			wl = int_width(lt);
			wr = int_width(rt);
			if (wl == 8)
				d.ty = (wr <= 16) ? TY_I32 : rt;
			else
				d.ty = (wr < wl) ? lt : rt;
			d.val = (widen_int(lt, lv) - widen_int(rt, rv)) & low_mask(int_width(d.ty));
		end
		return d;
	endfunction

	task automatic send_beat(input logic [3:0] lt, input logic [63:0] lv,
		input logic [3:0] rt, input logic [63:0] rv);
		diff_t d;
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_type <= lt;
		left_value <= lv;
		right_type <= rt;
		right_value <= rv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		d = predict_difference(lt, lv, rt, rv);
		pending_diffs.push_back(d);
		beats_sent++;
		if (!d.acc)
			n_reject++;
		else if (d.ty == TY_F32 || d.ty == TY_F64)
			n_float++;
		else
			n_int++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_diffs.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [3:0] pick_type();
		logic [3:0] t;
		if ($urandom_range(0, 99) < 88)
			return 4'($urandom_range(TY_I8, TY_F64));
		t = 4'($urandom_range(0, 15));
		return (t >= TY_I8 && t <= TY_F64) ? TY_PTR : t;
	endfunction

	function automatic logic [63:0] pick_value(input logic [3:0] t);
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: r = '0;
			1: r = '1;
			2: r = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
			3: begin
				if (t == TY_F32)
					r[30:23] = 8'hFF;
				else
					r[62:52] = 11'h7FF;
				if ($urandom_range(0, 1) == 0)
					r[51:0] = '0;
				if ($urandom_range(0, 1) == 0 && t == TY_F32)
					r[22:0] = '0;
			end
			4: begin
				if (t == TY_F32)
					r[30:23] = 8'h00;
				else
					r[62:52] = 11'h000;
			end
			5: begin
				if (t == TY_F32)
					r[30:23] = 8'($urandom_range(120, 134));
				else
					r[62:52] = 11'($urandom_range(1010, 1040));
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic test_directed();
		send_beat(TY_I8, 64'hFFFF_FFFF_FFFF_FF7F, TY_I8, 64'h80);
		send_beat(TY_U8, 64'hFF, TY_U16, 64'hFFFF);
		send_beat(TY_I16, 64'h8000, TY_U8, 64'h1);
		send_beat(TY_U32, 64'h0, TY_I32, 64'h1);
		send_beat(TY_I64, 64'h8000_0000_0000_0000, TY_I64, 64'h1);
		send_beat(TY_U64, 64'h0, TY_U64, '1);
		send_beat(TY_I32, 64'h5, TY_U64, 64'h7);
		send_beat(TY_U16, 64'hABCD_0000_0000_8000, TY_I32, 64'h7FFF_FFFF);
		send_beat(TY_F32, 64'hDEAD_BEEF_3F80_0000, TY_I32, 64'h7FFF_FFFF);
		send_beat(TY_U64, '1, TY_F64, 64'h0);
		send_beat(TY_I64, 64'h8000_0000_0000_0000, TY_F32, 64'h3F80_0000);
		send_beat(TY_U64, 64'hFFFF_FF80_0000_0001, TY_F32, 64'h0);
		send_beat(TY_I8, 64'h80, TY_F64, 64'h3FF0_0000_0000_0000);
		send_beat(TY_F64, 64'h7FF0_0000_0000_0000, TY_F64, 64'h7FF0_0000_0000_0000);
		send_beat(TY_F32, 64'h7FA0_0001, TY_F64, 64'h3FF0_0000_0000_0000);
		send_beat(TY_F64, 64'h3FF0_0000_0000_0000, TY_F64, 64'hFFF4_0000_0000_0001);
		send_beat(TY_F32, 64'h0000_0001, TY_F32, 64'h0080_0000);
		send_beat(TY_F32, 64'h7F7F_FFFF, TY_F32, 64'hFF7F_FFFF);
		send_beat(TY_F64, 64'h0, TY_F64, 64'h8000_0000_0000_0000);
		send_beat(TY_F32, 64'h8000_0000, TY_U8, 64'h0);
		send_beat(TY_BOOL, 64'h1234_5678_9ABC_DEF0, TY_I32, 64'h1);
		send_beat(TY_I32, 64'h1, TY_PTR, 64'hFFFF);
		send_beat(4'd15, '1, TY_F64, 64'h0);
		send_beat(TY_U8, 64'h7, 4'd12, 64'h3);
		wait_drained();
	endtask

	task automatic test_random_mix(input int count);
		logic [3:0]  lt;
		logic [3:0]  rt;
		logic [63:0] lv;
		logic [63:0] rv;
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 3 && i < count / 3 + 200);
			lt = pick_type();
			rt = pick_type();
			lv = pick_value(lt);
			rv = pick_value(rt);
			// Near-equal operands exercise cancellation in the float path.
			if ($urandom_range(0, 9) == 0)
				rv = lv ^ (64'd1 << $urandom_range(0, 63));
			send_beat(lt, lv, rt, rv);
		end
		calm = 1'b0;
		wait_drained();
	endtask

	task automatic test_output_stall();
		calm = 1'b1;
		hold_until = rx_cycle + 300;
		for (int i = 0; i < 60; i++)
			send_beat(pick_type(), {$urandom, $urandom}, pick_type(), {$urandom, $urandom});
		calm = 1'b0;
		wait_drained();
	endtask

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle < hold_until)
			out_ready <= 1'b0;
		else if (calm)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 99) >= 17);
	end

	always @(posedge clk) begin
		diff_t d;
		if (arst_n && out_valid && out_ready) begin
			if (pending_diffs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: type %0d value %h ok %b",
						result_type, result_value, ok);
			end else begin
				d = pending_diffs.pop_front();
				beats_checked++;
				if (result_type !== d.ty || result_value !== d.val || ok !== d.acc) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %h %b, got %0d %h %b",
							d.ty, d.val, d.acc, result_type, result_value, ok);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(1000);
		test_output_stall();
		repeat (20) @(posedge clk);
		$display("Checked %0d of %0d beats: %0d integer, %0d float, %0d rejected.",
			beats_checked, beats_sent, n_int, n_float, n_reject);
		$display("Included a long output stall and drains between phases.");
		if (mismatches == 0 && pending_diffs.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/tsp_pkg.sv
rtl/typed_subtract_with_promotion_core.sv
test/typed_subtract_with_promotion_core_tb.sv
